### src/lsc_pkg.sv
// Shared types, widths and constants of the point-light triangle culler.
`default_nettype none

package lsc_pkg;

  // Defaults of the top-level parameters
  localparam int MAX_VERTS_DEF   = 1024;
  localparam int MAX_INDEXES_DEF = 4096;

  // Field widths
  localparam int POS_W  = 24;
  localparam int NORM_W = 16;
  localparam int IDX_W  = 10;
  localparam int RAD_W  = 23;
  localparam int CNT_W  = 11;
  localparam int CODE_W = 6;

  // Arithmetic widths: light minus position, one product, sum of three
  localparam int DIFF_W = POS_W + 1;
  localparam int PROD_W = DIFF_W + NORM_W;
  localparam int DOT_W  = PROD_W + 2;

  localparam logic [CODE_W-1:0] CODE_ALL = '1;
  localparam int CNT_MAX = (2 ** CNT_W) - 1;

  // Configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef enum logic [1:0] {
    REG_LIGHT_X  = 2'd0,
    REG_LIGHT_Y  = 2'd1,
    REG_LIGHT_Z  = 2'd2,
    REG_LIGHT_RAD = 2'd3
  } lsc_reg_t;

  typedef enum logic [1:0] {
    ACT_START    = 2'd0,
    ACT_VERTEX   = 2'd1,
    ACT_TRIANGLE = 2'd2,
    ACT_NONE     = 2'd3
  } lsc_action_t;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    OP_CLEAR = 1'b0,
    OP_TRI   = 1'b1
  } lsc_op_t;

  typedef struct packed {
    lsc_op_t          op;
    logic             keep;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic             last;
  } lsc_entry_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } lsc_qstat_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [RAD_W-1:0]        radius;
  } lsc_light_t;

endpackage

`default_nettype wire

### src/lsc_if.sv
// Valid/ready channel interfaces for vertex/triangle items and cull results.
`default_nettype none

interface lsc_in_if import lsc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [IDX_W-1:0]         vertex_index;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic signed [NORM_W-1:0] norm_x;
  logic signed [NORM_W-1:0] norm_y;
  logic signed [NORM_W-1:0] norm_z;
  logic [IDX_W-1:0]         index_a;
  logic [IDX_W-1:0]         index_b;
  logic [IDX_W-1:0]         index_c;
  logic                     last_item;

  modport source (
    output valid, action, vertex_index, pos_x, pos_y, pos_z,
           norm_x, norm_y, norm_z, index_a, index_b, index_c, last_item,
    input  ready
  );
  modport sink (
    input  valid, action, vertex_index, pos_x, pos_y, pos_z,
           norm_x, norm_y, norm_z, index_a, index_b, index_c, last_item,
    output ready
  );
endinterface

interface lsc_out_if import lsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             keep;
  logic [IDX_W-1:0] out_a;
  logic [IDX_W-1:0] out_b;
  logic [IDX_W-1:0] out_c;
  logic [CNT_W-1:0] kept_count;
  logic [CNT_W-1:0] culled_count;
  logic             surface_done;

  modport source (
    output valid, keep, out_a, out_b, out_c, kept_count, culled_count, surface_done,
    input  ready
  );
  modport sink (
    input  valid, keep, out_a, out_b, out_c, kept_count, culled_count, surface_done,
    output ready
  );
endinterface

`default_nettype wire

### src/lsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/lsc_front.sv
// Front end: takes items, computes vertex outcodes into the code store and
// looks up triangle codes, handing triangles and surface starts to the queue.
`default_nettype none

module lsc_front import lsc_pkg::*; #(
  parameter int MAX_VERTS = MAX_VERTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  lsc_in_if.sink          in_ch,
  input  wire lsc_light_t light,
  input  wire lsc_qstat_t qstat,
  output logic            q_push,
  output lsc_entry_t      q_data
);

  localparam int AW = $clog2(MAX_VERTS);

  lsc_action_t act;
  logic        acc;
  logic        vert_busy;
  logic        space_ok;

  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic signed [DIFF_W-1:0] rad_pos, rad_neg;
  logic [CODE_W-1:0]        code_in;

  // vertex stage 1
  logic                     v1_r;
  logic signed [DIFF_W-1:0] d_x_r, d_y_r, d_z_r;
  logic signed [NORM_W-1:0] n_x_r, n_y_r, n_z_r;
  logic [CODE_W-1:0]        code1_r;
  logic [AW-1:0]            slot1_r;
  logic                     inr1_r;

  // vertex stage 2
  logic                     v2_r;
  logic signed [PROD_W-1:0] p_x_r, p_y_r, p_z_r;
  logic [CODE_W-1:0]        code2_r;
  logic [AW-1:0]            slot2_r;
  logic                     inr2_r;

  logic signed [DOT_W-1:0]  dot;
  logic                     we;
  logic [CODE_W-1:0]        wcode;

  // triangle lookup stage
  logic             t1_r;
  lsc_op_t          t_op_r;
  logic [IDX_W-1:0] t_a_r, t_b_r, t_c_r;
  logic             t_last_r;
  logic             in_a_r, in_b_r, in_c_r;
  logic [CODE_W-1:0] rd_a, rd_b, rd_c;
  logic [CODE_W-1:0] code_a, code_b, code_c;

  assign act = lsc_action_t'(in_ch.action);
  assign acc = in_ch.valid & in_ch.ready;

  // a triangle may only read once every earlier vertex has been written
  assign vert_busy = v1_r | v2_r;
  assign space_ok  = ((QCNT_W+1)'(qstat.count) + (QCNT_W+1)'(t1_r))
                     < (QCNT_W+1)'(QDEPTH);

  always_comb begin
    case (act)
      ACT_START:    in_ch.ready = space_ok;
      ACT_TRIANGLE: in_ch.ready = space_ok & ~vert_busy;
      default:      in_ch.ready = 1'b1;
    endcase
  end

  // light minus vertex position and the per-axis cube tests
  assign dx = $signed({light.x[POS_W-1], light.x}) - $signed({in_ch.pos_x[POS_W-1], in_ch.pos_x});
  assign dy = $signed({light.y[POS_W-1], light.y}) - $signed({in_ch.pos_y[POS_W-1], in_ch.pos_y});
  assign dz = $signed({light.z[POS_W-1], light.z}) - $signed({in_ch.pos_z[POS_W-1], in_ch.pos_z});
  assign rad_pos = $signed({2'b00, light.radius});
  assign rad_neg = -rad_pos;

  function automatic logic [1:0] axis_code(input logic signed [DIFF_W-1:0] d,
                                           input logic signed [DIFF_W-1:0] hi,
                                           input logic signed [DIFF_W-1:0] lo);
    logic [1:0] c;
    c = 2'b00;
    if (d > hi) begin
      c = 2'b01;
    end else if (d < lo) begin
      c = 2'b10;
    end
    return c;
  endfunction

  assign code_in = {axis_code(dz, rad_pos, rad_neg),
                    axis_code(dy, rad_pos, rad_neg),
                    axis_code(dx, rad_pos, rad_neg)};

  // vertex pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= acc & (act == ACT_VERTEX);
      v2_r <= v1_r;
    end
  end

  // vertex pipeline payload
  always_ff @(posedge clk) begin
    d_x_r   <= dx;
    d_y_r   <= dy;
    d_z_r   <= dz;
    n_x_r   <= in_ch.norm_x;
    n_y_r   <= in_ch.norm_y;
    n_z_r   <= in_ch.norm_z;
    code1_r <= code_in;
    slot1_r <= AW'(in_ch.vertex_index);
    inr1_r  <= 32'(in_ch.vertex_index) < 32'(MAX_VERTS);

    p_x_r   <= d_x_r * n_x_r;
    p_y_r   <= d_y_r * n_y_r;
    p_z_r   <= d_z_r * n_z_r;
    code2_r <= code1_r;
    slot2_r <= slot1_r;
    inr2_r  <= inr1_r;
  end

  // facing test and code store write
  assign dot = $signed({{2{p_x_r[PROD_W-1]}}, p_x_r})
             + $signed({{2{p_y_r[PROD_W-1]}}, p_y_r})
             + $signed({{2{p_z_r[PROD_W-1]}}, p_z_r});
  assign we    = v2_r & inr2_r;
  assign wcode = (dot <= 0) ? CODE_ALL : code2_r;

  // one store copy per triangle corner, written alike
  lsc_ram #(.WIDTH(CODE_W), .DEPTH(MAX_VERTS)) u_ram_a (
    .clk(clk), .we(we), .waddr(slot2_r), .wdata(wcode),
    .raddr(AW'(in_ch.index_a)), .rdata(rd_a)
  );
  lsc_ram #(.WIDTH(CODE_W), .DEPTH(MAX_VERTS)) u_ram_b (
    .clk(clk), .we(we), .waddr(slot2_r), .wdata(wcode),
    .raddr(AW'(in_ch.index_b)), .rdata(rd_b)
  );
  lsc_ram #(.WIDTH(CODE_W), .DEPTH(MAX_VERTS)) u_ram_c (
    .clk(clk), .we(we), .waddr(slot2_r), .wdata(wcode),
    .raddr(AW'(in_ch.index_c)), .rdata(rd_c)
  );

  // lookup stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= 1'b0;
    end else begin
      t1_r <= acc & ((act == ACT_START) | (act == ACT_TRIANGLE));
    end
  end

  // lookup stage payload
  always_ff @(posedge clk) begin
    t_op_r   <= (act == ACT_TRIANGLE) ? OP_TRI : OP_CLEAR;
    t_a_r    <= in_ch.index_a;
    t_b_r    <= in_ch.index_b;
    t_c_r    <= in_ch.index_c;
    t_last_r <= in_ch.last_item;
    in_a_r   <= 32'(in_ch.index_a) < 32'(MAX_VERTS);
    in_b_r   <= 32'(in_ch.index_b) < 32'(MAX_VERTS);
    in_c_r   <= 32'(in_ch.index_c) < 32'(MAX_VERTS);
  end

  // slots beyond the store read as an empty code
  assign code_a = in_a_r ? rd_a : '0;
  assign code_b = in_b_r ? rd_b : '0;
  assign code_c = in_c_r ? rd_c : '0;

  assign q_push      = t1_r;
  assign q_data.op   = t_op_r;
  assign q_data.keep = ((code_a & code_b & code_c) == '0);
  assign q_data.a    = t_a_r;
  assign q_data.b    = t_b_r;
  assign q_data.c    = t_c_r;
  assign q_data.last = t_last_r;

endmodule

`default_nettype wire

### src/lsc_queue.sv
// Short FIFO of triangle verdicts and surface starts between front and back.
`default_nettype none

module lsc_queue import lsc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire lsc_entry_t din,
  input  wire logic       pop,
  output lsc_entry_t      dout,
  output lsc_qstat_t      qstat
);

  lsc_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  // pointers and fill level; the front never pushes into a full queue
  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout        = mem_r[rd_ptr_r];
  assign qstat.count = count_r;
  assign qstat.empty = (count_r == '0);

endmodule

`default_nettype wire

### src/lsc_back.sv
// Back end: keeps the saturating kept/culled counters and drives results.
`default_nettype none

module lsc_back import lsc_pkg::*; #(
  parameter int MAX_INDEXES = MAX_INDEXES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire lsc_qstat_t qstat,
  input  wire lsc_entry_t q_data,
  output logic            q_pop,
  lsc_out_if.source       out_ch
);

  localparam int CntLimit = (MAX_INDEXES / 3 > CNT_MAX) ? CNT_MAX : MAX_INDEXES / 3;

  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             load;
  logic [CNT_W-1:0] kept_r, kept_nxt;
  logic [CNT_W-1:0] culled_r, culled_nxt;

  logic             keep_r;
  logic [IDX_W-1:0] a_r, b_r, c_r;
  logic [CNT_W-1:0] kept_out_r, culled_out_r;
  logic             done_r;

  // a start drains at once; a triangle waits for a free output register
  assign out_free = ~out_valid_r | out_ch.ready;
  assign q_pop    = ~qstat.empty & ((q_data.op == OP_CLEAR) | out_free);

  // counter update
  always_comb begin
    kept_nxt   = kept_r;
    culled_nxt = culled_r;
    load       = 1'b0;
    if (q_pop) begin
      case (q_data.op)
        OP_CLEAR: begin
          kept_nxt   = '0;
          culled_nxt = '0;
        end
        OP_TRI: begin
          load = 1'b1;
          if (q_data.keep) begin
            if (kept_r < CNT_W'(CntLimit)) begin
              kept_nxt = kept_r + 1'b1;
            end
          end else begin
            if (culled_r < CNT_W'(CntLimit)) begin
              culled_nxt = culled_r + 1'b1;
            end
          end
        end
        default: load = 1'b0;
      endcase
    end
  end

  assign out_valid_nxt = load | (out_valid_r & ~out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      kept_r      <= '0;
      culled_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      kept_r      <= kept_nxt;
      culled_r    <= culled_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      keep_r       <= q_data.keep;
      a_r          <= q_data.a;
      b_r          <= q_data.b;
      c_r          <= q_data.c;
      kept_out_r   <= kept_nxt;
      culled_out_r <= culled_nxt;
      done_r       <= q_data.last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.keep         = keep_r;
  assign out_ch.out_a        = a_r;
  assign out_ch.out_b        = b_r;
  assign out_ch.out_c        = c_r;
  assign out_ch.kept_count   = kept_out_r;
  assign out_ch.culled_count = culled_out_r;
  assign out_ch.surface_done = done_r;

endmodule

`default_nettype wire

### src/light_sphere_triangle_cull.sv
// Point-light triangle culler: one item per cycle unless the queue is full or a
// triangle waits for a vertex code write. A vertex code is written to the store
// after its difference and product registers; a triangle item is held at the input
// until that write has landed. A triangle result goes through the lookup stage and a 4-deep queue.
// Reset clears control state, counters and light registers; the code store is
// not cleared and holds no valid bits.
`default_nettype none

module light_sphere_triangle_cull import lsc_pkg::*; #(
  parameter int MAX_VERTS   = MAX_VERTS_DEF,
  parameter int MAX_INDEXES = MAX_INDEXES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  lsc_in_if.sink                 in_ch,
  lsc_out_if.source              out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  lsc_light_t light_r;
  lsc_reg_t   reg_sel;
  logic       cfg_wr;
  lsc_qstat_t qstat;
  lsc_entry_t q_in, q_out;
  logic       q_push, q_pop;

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = lsc_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_LIGHT_X:   light_r.x      <= cfg_pwdata[POS_W-1:0];
        REG_LIGHT_Y:   light_r.y      <= cfg_pwdata[POS_W-1:0];
        REG_LIGHT_Z:   light_r.z      <= cfg_pwdata[POS_W-1:0];
        REG_LIGHT_RAD: light_r.radius <= cfg_pwdata[RAD_W-1:0];
        default:       light_r        <= light_r;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      REG_LIGHT_X:   cfg_prdata = CFG_DW'(unsigned'(light_r.x));
      REG_LIGHT_Y:   cfg_prdata = CFG_DW'(unsigned'(light_r.y));
      REG_LIGHT_Z:   cfg_prdata = CFG_DW'(unsigned'(light_r.z));
      REG_LIGHT_RAD: cfg_prdata = CFG_DW'(light_r.radius);
      default:       cfg_prdata = '0;
    endcase
  end

  lsc_front #(.MAX_VERTS(MAX_VERTS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .light  (light_r),
    .qstat  (qstat),
    .q_push (q_push),
    .q_data (q_in)
  );

  lsc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .qstat (qstat)
  );

  lsc_back #(.MAX_INDEXES(MAX_INDEXES)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .qstat  (qstat),
    .q_data (q_out),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the point-light triangle culler.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsc_pkg::*;

  localparam int     CULL_LIMIT = (MAX_INDEXES_DEF / 3 > CNT_MAX) ? CNT_MAX : MAX_INDEXES_DEF / 3;
  localparam longint POS_HI     = (longint'(1) <<< (POS_W - 1)) - 1;
  localparam longint POS_LO     = -POS_HI - 1;

  typedef struct {
    lsc_action_t              action;
    logic [IDX_W-1:0]         vertex_index;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic [IDX_W-1:0]         index_a;
    logic [IDX_W-1:0]         index_b;
    logic [IDX_W-1:0]         index_c;
    logic                     last_item;
  } cull_item_t;

  typedef struct packed {
    logic             keep;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic [CNT_W-1:0] kept;
    logic [CNT_W-1:0] culled;
    logic             done;
  } cull_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  lsc_in_if  in_ch();
  lsc_out_if out_ch();

  light_sphere_triangle_cull u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  // Predictor state: light registers, code store, surface counters
  logic signed [POS_W-1:0] light_x;
  logic signed [POS_W-1:0] light_y;
  logic signed [POS_W-1:0] light_z;
  logic [RAD_W-1:0]        light_radius;
  logic [CODE_W-1:0]       code_store [MAX_VERTS_DEF];
  logic [CNT_W-1:0]        kept_tris;
  logic [CNT_W-1:0]        culled_tris;
  cull_result_t            expected_culls [$];

  // Stimulus bookkeeping
  cull_item_t pending_items [$];
  bit         slot_used [MAX_VERTS_DEF];
  int         written_slots [$];
  int         items_queued = 0;
  int         items_taken  = 0;
  int         mismatches   = 0;
  int         tx_idle_pct  = 0;
  int         rx_stall_pct = 0;
  logic       rx_hold      = 1'b0;
  logic       in_took      = 1'b0;

  // Outcode of one vertex against the light cube; all ones when facing away
  function automatic logic [CODE_W-1:0] clip_code(cull_item_t it);
    longint dx, dy, dz, dot, r;
    logic [CODE_W-1:0] code;
    dx  = longint'($signed(light_x)) - longint'($signed(it.pos_x));
    dy  = longint'($signed(light_y)) - longint'($signed(it.pos_y));
    dz  = longint'($signed(light_z)) - longint'($signed(it.pos_z));
    dot = dx * longint'($signed(it.norm_x)) + dy * longint'($signed(it.norm_y))
        + dz * longint'($signed(it.norm_z));
    r   = longint'(light_radius);
    if (dot <= 0) return CODE_ALL;
    code = '0;
    if (dx > r) code[0] = 1'b1; else if (dx < -r) code[1] = 1'b1;
    if (dy > r) code[2] = 1'b1; else if (dy < -r) code[3] = 1'b1;
    if (dz > r) code[4] = 1'b1; else if (dz < -r) code[5] = 1'b1;
    return code;
  endfunction

  // Advance the predictor by one transferred item
  function automatic void predict_cull(cull_item_t it);
    cull_result_t res;
    case (it.action)
      ACT_START: begin
        kept_tris   = '0;
        culled_tris = '0;
      end
      ACT_VERTEX: code_store[it.vertex_index] = clip_code(it);
      ACT_TRIANGLE: begin
        res.keep = (code_store[it.index_a] & code_store[it.index_b]
                    & code_store[it.index_c]) == '0;
        if (res.keep) begin
          if (kept_tris < CULL_LIMIT) kept_tris++;
        end else if (culled_tris < CULL_LIMIT) begin
          culled_tris++;
        end
        res.a      = it.index_a;
        res.b      = it.index_b;
        res.c      = it.index_c;
        res.kept   = kept_tris;
        res.culled = culled_tris;
        res.done   = it.last_item;
        expected_culls.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function automatic string cull_str(cull_result_t r);
    return $sformatf("keep=%0b idx=(%0d,%0d,%0d) kept=%0d culled=%0d done=%0b",
                     r.keep, r.a, r.b, r.c, r.kept, r.culled, r.done);
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  // Input transfers feed the predictor
  always @(posedge clk) begin : in_mon
    cull_item_t seen;
    in_took <= in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen.action       = lsc_action_t'(in_ch.action);
      seen.vertex_index = in_ch.vertex_index;
      seen.pos_x        = in_ch.pos_x;
      seen.pos_y        = in_ch.pos_y;
      seen.pos_z        = in_ch.pos_z;
      seen.norm_x       = in_ch.norm_x;
      seen.norm_y       = in_ch.norm_y;
      seen.norm_z       = in_ch.norm_z;
      seen.index_a      = in_ch.index_a;
      seen.index_b      = in_ch.index_b;
      seen.index_c      = in_ch.index_c;
      seen.last_item    = in_ch.last_item;
      predict_cull(seen);
      items_taken++;
    end
  end

  // Result transfers checked against the oldest prediction
  always @(posedge clk) begin : out_mon
    cull_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{keep: out_ch.keep, a: out_ch.out_a, b: out_ch.out_b, c: out_ch.out_c,
              kept: out_ch.kept_count, culled: out_ch.culled_count,
              done: out_ch.surface_done};
      if (expected_culls.size() == 0) begin
        flag_mismatch({"unexpected result: got ", cull_str(got)});
      end else begin
        want = expected_culls.pop_front();
        if (got !== want)
          flag_mismatch({"result mismatch: expected ", cull_str(want), " got ", cull_str(got)});
      end
    end
  end

  // Input driver: hold each item until its transfer, idle at random in between
  always @(negedge clk) begin : in_drv
    cull_item_t cur;
    if (!in_ch.valid || in_took) begin
      if (rst_n && pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        cur = pending_items.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.action       <= cur.action;
        in_ch.vertex_index <= cur.vertex_index;
        in_ch.pos_x        <= cur.pos_x;
        in_ch.pos_y        <= cur.pos_y;
        in_ch.pos_z        <= cur.pos_z;
        in_ch.norm_x       <= cur.norm_x;
        in_ch.norm_y       <= cur.norm_y;
        in_ch.norm_z       <= cur.norm_z;
        in_ch.index_a      <= cur.index_a;
        in_ch.index_b      <= cur.index_b;
        in_ch.index_c      <= cur.index_c;
        in_ch.last_item    <= cur.last_item;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus the long hold-off
  always @(negedge clk)
    out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);

  // Item with every field random; callers overwrite what matters
  function automatic cull_item_t blank_item(lsc_action_t act);
    cull_item_t it;
    it.action       = act;
    it.vertex_index = IDX_W'($urandom);
    it.pos_x        = POS_W'($urandom);
    it.pos_y        = POS_W'($urandom);
    it.pos_z        = POS_W'($urandom);
    it.norm_x       = NORM_W'($urandom);
    it.norm_y       = NORM_W'($urandom);
    it.norm_z       = NORM_W'($urandom);
    it.index_a      = IDX_W'($urandom);
    it.index_b      = IDX_W'($urandom);
    it.index_c      = IDX_W'($urandom);
    it.last_item    = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic void push_item(cull_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endfunction

  function automatic void queue_vertex(int slot, int px, int py, int pz,
                                       int nx, int ny, int nz);
    cull_item_t it;
    it = blank_item(ACT_VERTEX);
    it.vertex_index = IDX_W'(slot);
    it.pos_x  = POS_W'(px);
    it.pos_y  = POS_W'(py);
    it.pos_z  = POS_W'(pz);
    it.norm_x = NORM_W'(nx);
    it.norm_y = NORM_W'(ny);
    it.norm_z = NORM_W'(nz);
    if (!slot_used[slot]) begin
      slot_used[slot] = 1'b1;
      written_slots.push_back(slot);
    end
    push_item(it);
  endfunction

  function automatic void queue_triangle(int a, int b, int c, bit last);
    cull_item_t it;
    it = blank_item(ACT_TRIANGLE);
    it.index_a   = IDX_W'(a);
    it.index_b   = IDX_W'(b);
    it.index_c   = IDX_W'(c);
    it.last_item = last;
    push_item(it);
  endfunction

  // Coordinate near the light on one axis, so codes are mixed; sometimes anywhere
  function automatic int near_coord(logic signed [POS_W-1:0] centre);
    longint v;
    if ($urandom_range(3) == 0) return int'($signed(POS_W'($urandom)));
    v = longint'($signed(centre)) + longint'($urandom_range(2 * light_radius + 4))
      - (longint'(light_radius) + 2);
    if (v > POS_HI) v = POS_HI;
    if (v < POS_LO) v = POS_LO;
    return int'(v);
  endfunction

  function automatic void queue_rand_vertex(int slot);
    int nx, ny, nz;
    nx = $urandom_range(65535) - 32768;
    ny = $urandom_range(65535) - 32768;
    nz = $urandom_range(65535) - 32768;
    if ($urandom_range(99) < 8) begin
      nx = 0;
      ny = 0;
      nz = 0;
    end
    if ($urandom_range(99) < 8)
      queue_vertex(slot, light_x, light_y, light_z, nx, ny, nz);
    else
      queue_vertex(slot, near_coord(light_x), near_coord(light_y), near_coord(light_z),
                   nx, ny, nz);
  endfunction

  // Mostly vertices of this surface, now and then any slot written so far
  function automatic int pick_slot(int surf[$]);
    if (surf.size() != 0 && $urandom_range(99) < 85)
      return surf[$urandom_range(surf.size() - 1)];
    return written_slots[$urandom_range(written_slots.size() - 1)];
  endfunction

  // Mostly well-formed surfaces with random content, the rest loose noise
  function automatic void queue_random(int n);
    int made, nv, nt, slot;
    int surf [$];
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 80) begin
        surf.delete();
        push_item(blank_item(ACT_START));
        nv = $urandom_range(1, 12);
        repeat (nv) begin
          slot = $urandom_range(MAX_VERTS_DEF - 1);
          queue_rand_vertex(slot);
          surf.push_back(slot);
        end
        nt = $urandom_range(1, 10);
        for (int i = 0; i < nt; i++)
          queue_triangle(pick_slot(surf), pick_slot(surf), pick_slot(surf), i == nt - 1);
        made += 1 + nv + nt;
      end else begin
        surf.delete();
        case ($urandom_range(3))
          0: push_item(blank_item(ACT_NONE));
          1: queue_triangle(pick_slot(surf), pick_slot(surf), pick_slot(surf),
                            $urandom_range(1));
          2: queue_rand_vertex($urandom_range(MAX_VERTS_DEF - 1));
          default: push_item(blank_item(ACT_START));
        endcase
        made++;
      end
    end
  endfunction

  // One register write: setup cycle, then access cycle until pready
  task automatic cfg_write(lsc_reg_t r, int value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = CFG_AW'({r, 2'b00});
    cfg_pwdata  = CFG_DW'(value) & 32'h00FF_FFFF;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (r)
      REG_LIGHT_X:   light_x      = POS_W'(value);
      REG_LIGHT_Y:   light_y      = POS_W'(value);
      REG_LIGHT_Z:   light_z      = POS_W'(value);
      REG_LIGHT_RAD: light_radius = RAD_W'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic set_light(int x, int y, int z, int radius);
    cfg_write(REG_LIGHT_X, x);
    cfg_write(REG_LIGHT_Y, y);
    cfg_write(REG_LIGHT_Z, z);
    cfg_write(REG_LIGHT_RAD, radius);
    @(posedge clk);
  endtask

  // All items transferred and all results in, then let vertex writes land
  task automatic wait_drained();
    do @(negedge clk);
    while (items_taken != items_queued || expected_culls.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, int n);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    queue_random(n);
    wait_drained();
  endtask

  initial begin : stimulus
    rst_n              = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_START;
    in_ch.vertex_index = '0;
    in_ch.pos_x        = '0;
    in_ch.pos_y        = '0;
    in_ch.pos_z        = '0;
    in_ch.norm_x       = '0;
    in_ch.norm_y       = '0;
    in_ch.norm_z       = '0;
    in_ch.index_a      = '0;
    in_ch.index_b      = '0;
    in_ch.index_c      = '0;
    in_ch.last_item    = 1'b0;
    out_ch.ready       = 1'b0;
    light_x            = '0;
    light_y            = '0;
    light_z            = '0;
    light_radius       = '0;
    kept_tris          = '0;
    culled_tris        = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed: each axis bit, cube boundary, facing away, zero dot, ignored action
    set_light(1000, -2000, 0, 100);
    push_item(blank_item(ACT_START));
    queue_vertex(0, 899, -2000, 0, 16384, 0, 0);          // x above
    queue_vertex(1, 900, -1899, 0, 16384, 0, 0);          // x on face, y below
    queue_vertex(2, 1100, -2000, -101, 0, 0, 16384);      // x on far face, z above
    queue_vertex(3, 899, -2000, 0, 0, 0, 0);              // zero normal
    queue_vertex(4, 1000, -2000, 0, 32767, 32767, 32767); // vertex at the light
    queue_vertex(5, 899, -2000, 0, -16384, 0, 0);         // facing away
    queue_vertex(6, 1000, -2000, 101, 0, 0, -32768);      // z below
    queue_vertex(7, 1000, -2101, 0, 0, 16384, 0);         // y above
    queue_vertex(1023, 1101, -2000, 0, -32768, 32767, 32767);
    queue_triangle(0, 1, 2, 1'b0);
    queue_triangle(3, 4, 5, 1'b0);
    queue_triangle(0, 3, 5, 1'b0);
    queue_triangle(1023, 1023, 1023, 1'b1);
    push_item(blank_item(ACT_NONE));
    queue_triangle(7, 6, 1023, 1'b0);                     // last flag alone keeps counts
    push_item(blank_item(ACT_START));
    queue_triangle(1023, 0, 1, 1'b0);
    queue_triangle(6, 6, 3, 1'b1);
    wait_drained();

    // Directed: light and positions at the extremes of the range
    set_light(8388607, -8388608, 8388607, 8388607);
    push_item(blank_item(ACT_START));
    queue_vertex(8, -8388608, 8388607, -8388608, 32767, -32768, 32767);
    queue_vertex(9, 0, -1, 0, 1, 0, 0);
    queue_triangle(8, 9, 8, 1'b0);
    queue_triangle(8, 8, 8, 1'b1);
    wait_drained();

    // Random phases, one light setting and one idling pattern each
    set_light($urandom, $urandom, $urandom, $urandom_range(4096));
    run_phase(0, 0, 170);
    set_light(0, 0, 0, 0);
    run_phase(65, 0, 170);
    set_light(-8388608, -8388608, -8388608, 8388607);
    run_phase(0, 65, 170);
    set_light($urandom, $urandom, $urandom, $urandom_range(8388607));
    run_phase(33, 33, 170);

    // Receiver holds off while the sender keeps offering: block fills and stalls
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold      = 1'b1;
    queue_random(40);
    repeat (80) @(posedge clk);
    rx_hold = 1'b0;
    wait_drained();

    repeat (20) @(posedge clk);
    if (expected_culls.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", expected_culls.size()));
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
src/lsc_pkg.sv
src/lsc_if.sv
src/lsc_ram.sv
src/lsc_front.sv
src/lsc_queue.sv
src/lsc_back.sv
src/light_sphere_triangle_cull.sv
dv/tb.sv
